FILE: rtl/rblb_pkg.sv
// ----------------------------------------------------------------------------
// rblb_pkg
// Shared types and constants for the range-bearing landmark birth pipeline.
// ----------------------------------------------------------------------------
package rblb_pkg;

  // Input word: one pose and one range-bearing measurement
  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic        [31:0] measured_range;
    logic signed [15:0] measured_bearing;
  } in_word_t;

  // Result word: landmark position and covariance
  typedef struct packed {
    logic signed [31:0] landmark_x;
    logic signed [31:0] landmark_y;
    logic signed [63:0] cov_xx;
    logic signed [63:0] cov_xy;
    logic signed [63:0] cov_yy;
  } out_word_t;

  // Register indexes
  localparam logic [1:0] REG_RANGE_VAR   = 2'd0;
  localparam logic [1:0] REG_CROSS_COV   = 2'd1;
  localparam logic [1:0] REG_BEARING_VAR = 2'd2;

  localparam logic signed [31:0] RANGE_VAR_RST   = 32'sd65536;
  localparam logic signed [31:0] CROSS_COV_RST   = 32'sd0;
  localparam logic signed [31:0] BEARING_VAR_RST = 32'sd65536;

  // Angle constants, Q3.13 and Q2.30
  localparam logic signed [17:0] PI_Q13          = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13      = 18'sd51472;
  localparam logic signed [34:0] PI_Q30          = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30     = 35'sd1686629713;
  localparam logic signed [34:0] QTR_PI_Q30      = 35'sd843314857;
  localparam logic signed [34:0] THREE_QTR_PI_Q30 = 35'sd2529944570;
  localparam logic [30:0]        ONE_Q30         = 31'd1073741824;

  // Reciprocals for exact floor division of values below 2^31:
  // shift = 31 + ceil(log2 d), magic = ceil(2^shift / d)
  localparam logic [5:0]  SH_72  = 6'd38;
  localparam logic [5:0]  SH_56  = 6'd37;
  localparam logic [5:0]  SH_42  = 6'd37;
  localparam logic [5:0]  SH_30  = 6'd36;
  localparam logic [5:0]  SH_20  = 6'd36;
  localparam logic [5:0]  SH_12  = 6'd35;
  localparam logic [5:0]  SH_6   = 6'd34;
  localparam longint unsigned MAG_72_W = ((64'd1 << 38) + 64'd71) / 64'd72;
  localparam longint unsigned MAG_56_W = ((64'd1 << 37) + 64'd55) / 64'd56;
  localparam longint unsigned MAG_42_W = ((64'd1 << 37) + 64'd41) / 64'd42;
  localparam longint unsigned MAG_30_W = ((64'd1 << 36) + 64'd29) / 64'd30;
  localparam longint unsigned MAG_20_W = ((64'd1 << 36) + 64'd19) / 64'd20;
  localparam longint unsigned MAG_12_W = ((64'd1 << 35) + 64'd11) / 64'd12;
  localparam longint unsigned MAG_6_W  = ((64'd1 << 34) + 64'd5) / 64'd6;
  localparam logic [31:0] MAG_72 = MAG_72_W[31:0];
  localparam logic [31:0] MAG_56 = MAG_56_W[31:0];
  localparam logic [31:0] MAG_42 = MAG_42_W[31:0];
  localparam logic [31:0] MAG_30 = MAG_30_W[31:0];
  localparam logic [31:0] MAG_20 = MAG_20_W[31:0];
  localparam logic [31:0] MAG_12 = MAG_12_W[31:0];
  localparam logic [31:0] MAG_6  = MAG_6_W[31:0];

  // Floor quotient of v by a small constant via its reciprocal
  function automatic logic [30:0] recip_div(input logic [30:0] v, input logic [31:0] mag,
                                           input logic [5:0] sh);
    logic [62:0] prod;
    logic [62:0] shr;
    prod = {32'b0, v} * {31'b0, mag};
    shr  = prod >> sh;
    return shr[30:0];
  endfunction

  // One Horner step: 1 - p / d
  function automatic logic [30:0] horner_step(input logic [30:0] p, input logic [31:0] mag,
                                             input logic [5:0] sh);
    return ONE_Q30 - recip_div(p, mag, sh);
  endfunction

endpackage

FILE: rtl/range_bearing_landmark_birth.sv
// ----------------------------------------------------------------------------
// range_bearing_landmark_birth
// Pipelined landmark initialization from a pose and a range-bearing fix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_word carries one pose plus one
//   range-bearing measurement. Result channel out_valid / out_stall /
//   out_word returns the landmark position and its 2x2 covariance G*R*G'.
//   Configuration channel cfg_valid / cfg_ready / cfg_index / cfg_data
//   writes the three noise registers (range var, cross cov, bearing var);
//   cfg_ready is always high, an index past the list is dropped.
//   Throughput: one word per cycle while the receiver does not stall;
//   the sine/cosine Horner chain, the 32x32 multiplier stages and the split
//   64x32 covariance products form a 16-stage pipe plus the output register.
//   Reset empties the pipe and loads the noise registers with 1.0, 0, 1.0.
//   When the receiver stalls with a word waiting, the whole pipe holds and
//   in_stall goes high in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module range_bearing_landmark_birth (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rblb_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rblb_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import rblb_pkg::*;

  localparam int NSTG = 16;

  logic adv;
  logic [NSTG:1] vld_r;
  logic out_valid_r;
  out_word_t out_word_r;
  logic signed [31:0] noise_r [3];

  // carried payload
  logic signed [31:0] px_r [1:11];
  logic signed [31:0] py_r [1:11];
  logic        [31:0] rng_r [1:10];
  logic signed [30:0] y_r [1:9];
  logic        [1:0]  q_r [1:9];

  // sine/cosine chain
  logic [29:0] y2_r [2:7];
  logic [30:0] ts3_r, tc3_r, ps4_r, pc4_r, ts5_r, tc5_r, ps6_r, pc6_r;
  logic [30:0] ts7_r, tc7_r, ps8_r, pc8_r, ts9_r, c9_r;
  logic signed [31:0] s10_r, c10_r;

  // G products
  logic signed [33:0] rc11_r, rs11_r;
  logic signed [31:0] cc11_r, cs11_r, ss11_r, s11_r, c11_r;
  logic signed [31:0] cc12_r, cs12_r, ss12_r;
  logic signed [47:0] c_rs12_r, c_rc12_r, s_rs12_r, s_rc12_r;
  logic signed [63:0] rs_rs12_r, rs_rc12_r, rc_rc12_r;
  logic signed [31:0] lx_r [12:16];
  logic signed [31:0] ly_r [12:16];

  // covariance accumulation
  logic signed [63:0] g13_r [3][3];
  logic signed [64:0] lo14_r [3][3];
  logic signed [63:0] hi14_r [3][3];
  logic signed [66:0] lo15_r [3];
  logic signed [65:0] hi15_r [3];
  logic signed [97:0] acc16_r [3];

  // combinational
  logic signed [17:0] a_sum, a_w;
  logic signed [34:0] x_ang, y_full;
  logic        [1:0]  q_nxt;
  logic signed [61:0] y_sq;
  logic [60:0] ps4_p, pc4_p, ps6_p, pc6_p, ps8_p, pc8_p;
  logic signed [62:0] s_p;
  logic signed [31:0] s0, c0, s10_nxt, c10_nxt;
  logic signed [32:0] rng_s;
  logic signed [64:0] rc_p, rs_p;
  logic signed [63:0] cc_p, cs_p, ss_p;
  logic signed [65:0] c_rs_p, c_rc_p, s_rs_p, s_rc_p;
  logic signed [67:0] rs_rs_p, rs_rc_p, rc_rc_p;
  logic signed [34:0] lx_sum, ly_sum;
  logic signed [31:0] lx_nxt, ly_nxt;
  logic signed [63:0] g13_nxt [3][3];
  logic signed [97:0] acc_hi [3];
  logic signed [63:0] cov_nxt [3];

  // advance whenever the output register is free or drains
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r[0] <= RANGE_VAR_RST;
      noise_r[1] <= CROSS_COV_RST;
      noise_r[2] <= BEARING_VAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RANGE_VAR:   noise_r[0] <= cfg_data;
        REG_CROSS_COV:   noise_r[1] <= cfg_data;
        REG_BEARING_VAR: noise_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits and output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-1:1], in_valid};
      out_valid_r <= vld_r[NSTG];
    end
  end

  // Stage 1: wrap angle, scale to Q2.30, reduce to one quadrant
  always_comb begin
    a_sum = 18'(in_word.pose_heading) + 18'(in_word.measured_bearing);
    if (a_sum >= PI_Q13) begin
      a_w = a_sum - TWO_PI_Q13;
    end else if (a_sum < -PI_Q13) begin
      a_w = a_sum + TWO_PI_Q13;
    end else begin
      a_w = a_sum;
    end
    x_ang = {a_w, 17'b0};
    if (x_ang > THREE_QTR_PI_Q30) begin
      q_nxt = 2'd2; y_full = x_ang - PI_Q30;
    end else if (x_ang > QTR_PI_Q30) begin
      q_nxt = 2'd1; y_full = x_ang - HALF_PI_Q30;
    end else if (x_ang >= -QTR_PI_Q30) begin
      q_nxt = 2'd0; y_full = x_ang;
    end else if (x_ang >= -THREE_QTR_PI_Q30) begin
      q_nxt = 2'd3; y_full = x_ang + HALF_PI_Q30;
    end else begin
      q_nxt = 2'd2; y_full = x_ang + PI_Q30;
    end
  end

  // Stages 2..9: square, then Horner steps for sine and cosine
  assign y_sq  = y_r[1] * y_r[1];
  assign ps4_p = {31'b0, y2_r[3]} * {30'b0, ts3_r};
  assign pc4_p = {31'b0, y2_r[3]} * {30'b0, tc3_r};
  assign ps6_p = {31'b0, y2_r[5]} * {30'b0, ts5_r};
  assign pc6_p = {31'b0, y2_r[5]} * {30'b0, tc5_r};
  assign ps8_p = {31'b0, y2_r[7]} * {30'b0, ts7_r};
  assign pc8_p = {31'b0, y2_r[7]} * {30'b0, tc7_r};

  // Stage 10: sine multiply and quadrant map
  always_comb begin
    s_p = 63'(y_r[9]) * $signed({32'b0, ts9_r});
    s0  = s_p[61:30];
    c0  = $signed({1'b0, c9_r});
    case (q_r[9])
      2'd0: begin s10_nxt = s0;  c10_nxt = c0;  end
      2'd1: begin s10_nxt = c0;  c10_nxt = -s0; end
      2'd2: begin s10_nxt = -s0; c10_nxt = -c0; end
      default: begin s10_nxt = -c0; c10_nxt = s0; end
    endcase
  end

  // Stage 11 and 12 products
  assign rng_s   = $signed({1'b0, rng_r[10]});
  assign rc_p    = 65'(rng_s) * 65'(c10_r);
  assign rs_p    = 65'(rng_s) * 65'(s10_r);
  assign cc_p    = 64'(c10_r) * 64'(c10_r);
  assign cs_p    = 64'(c10_r) * 64'(s10_r);
  assign ss_p    = 64'(s10_r) * 64'(s10_r);
  assign c_rs_p  = 66'(c11_r) * 66'(rs11_r);
  assign c_rc_p  = 66'(c11_r) * 66'(rc11_r);
  assign s_rs_p  = 66'(s11_r) * 66'(rs11_r);
  assign s_rc_p  = 66'(s11_r) * 66'(rc11_r);
  assign rs_rs_p = 68'(rs11_r) * 68'(rs11_r);
  assign rs_rc_p = 68'(rs11_r) * 68'(rc11_r);
  assign rc_rc_p = 68'(rc11_r) * 68'(rc11_r);

  // Landmark position with saturation
  always_comb begin
    lx_sum = 35'(px_r[11]) + 35'(rc11_r);
    ly_sum = 35'(py_r[11]) + 35'(rs11_r);
    if (lx_sum > 35'sd2147483647) lx_nxt = 32'sh7fffffff;
    else if (lx_sum < -35'sd2147483648) lx_nxt = 32'sh80000000;
    else lx_nxt = lx_sum[31:0];
    if (ly_sum > 35'sd2147483647) ly_nxt = 32'sh7fffffff;
    else if (ly_sum < -35'sd2147483648) ly_nxt = 32'sh80000000;
    else ly_nxt = ly_sum[31:0];
  end

  // Stage 13: G*R*G' coefficient terms per entry
  always_comb begin
    g13_nxt[0][0] = 64'(cc12_r);
    g13_nxt[0][1] = -(64'(c_rs12_r) <<< 1);
    g13_nxt[0][2] = rs_rs12_r;
    g13_nxt[1][0] = 64'(cs12_r);
    g13_nxt[1][1] = 64'(c_rc12_r) - 64'(s_rs12_r);
    g13_nxt[1][2] = -rs_rc12_r;
    g13_nxt[2][0] = 64'(ss12_r);
    g13_nxt[2][1] = 64'(s_rc12_r) <<< 1;
    g13_nxt[2][2] = rc_rc12_r;
  end

  // Stage 16 combine, output saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_hi[i] = 98'(hi15_r[i]) <<< 32;
      if ((acc16_r[i][97:77] == '0) || (acc16_r[i][97:77] == '1)) begin
        cov_nxt[i] = acc16_r[i][77:14];
      end else if (acc16_r[i][97]) begin
        cov_nxt[i] = 64'sh8000000000000000;
      end else begin
        cov_nxt[i] = 64'sh7fffffffffffffff;
      end
    end
  end

  // Pipeline registers: all stages move together on advance
  always_ff @(posedge clk) begin
    if (adv) begin
      // carry payload along
      px_r[1]  <= in_word.pose_x;
      py_r[1]  <= in_word.pose_y;
      rng_r[1] <= in_word.measured_range;
      y_r[1]   <= y_full[30:0];
      q_r[1]   <= q_nxt;
      for (int k = 2; k <= 11; k++) begin
        px_r[k] <= px_r[k-1];
        py_r[k] <= py_r[k-1];
      end
      for (int k = 2; k <= 10; k++) begin
        rng_r[k] <= rng_r[k-1];
      end
      for (int k = 2; k <= 9; k++) begin
        y_r[k] <= y_r[k-1];
        q_r[k] <= q_r[k-1];
      end
      // square and Horner chain
      y2_r[2] <= y_sq[59:30];
      for (int k = 3; k <= 7; k++) begin
        y2_r[k] <= y2_r[k-1];
      end
      ts3_r <= horner_step({1'b0, y2_r[2]}, MAG_72, SH_72);
      tc3_r <= horner_step({1'b0, y2_r[2]}, MAG_56, SH_56);
      ps4_r <= ps4_p[60:30];
      pc4_r <= pc4_p[60:30];
      ts5_r <= horner_step(ps4_r, MAG_42, SH_42);
      tc5_r <= horner_step(pc4_r, MAG_30, SH_30);
      ps6_r <= ps6_p[60:30];
      pc6_r <= pc6_p[60:30];
      ts7_r <= horner_step(ps6_r, MAG_20, SH_20);
      tc7_r <= horner_step(pc6_r, MAG_12, SH_12);
      ps8_r <= ps8_p[60:30];
      pc8_r <= pc8_p[60:30];
      ts9_r <= horner_step(ps8_r, MAG_6, SH_6);
      c9_r  <= ONE_Q30 - (pc8_r >> 1);
      s10_r <= s10_nxt;
      c10_r <= c10_nxt;
      // G entries
      rc11_r <= rc_p[63:30];
      rs11_r <= rs_p[63:30];
      cc11_r <= cc_p[61:30];
      cs11_r <= cs_p[61:30];
      ss11_r <= ss_p[61:30];
      s11_r  <= s10_r;
      c11_r  <= c10_r;
      cc12_r <= cc11_r;
      cs12_r <= cs11_r;
      ss12_r <= ss11_r;
      c_rs12_r  <= c_rs_p[63:16];
      c_rc12_r  <= c_rc_p[63:16];
      s_rs12_r  <= s_rs_p[63:16];
      s_rc12_r  <= s_rc_p[63:16];
      rs_rs12_r <= rs_rs_p[65:2];
      rs_rc12_r <= rs_rc_p[65:2];
      rc_rc12_r <= rc_rc_p[65:2];
      lx_r[12]  <= lx_nxt;
      ly_r[12]  <= ly_nxt;
      for (int k = 13; k <= 16; k++) begin
        lx_r[k] <= lx_r[k-1];
        ly_r[k] <= ly_r[k-1];
      end
      // covariance: split 64x32 products, partial sums, final sum
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          g13_r[i][j]  <= g13_nxt[i][j];
          lo14_r[i][j] <= $signed({1'b0, g13_r[i][j][31:0]}) * 65'(noise_r[j]);
          hi14_r[i][j] <= 64'($signed(g13_r[i][j][63:32])) * 64'(noise_r[j]);
        end
        lo15_r[i]  <= 67'(lo14_r[i][0]) + 67'(lo14_r[i][1]) + 67'(lo14_r[i][2]);
        hi15_r[i]  <= 66'(hi14_r[i][0]) + 66'(hi14_r[i][1]) + 66'(hi14_r[i][2]);
        acc16_r[i] <= acc_hi[i] + 98'(lo15_r[i]);
      end
      // output word
      out_word_r.landmark_x <= lx_r[16];
      out_word_r.landmark_y <= ly_r[16];
      out_word_r.cov_xx     <= cov_nxt[0];
      out_word_r.cov_xy     <= cov_nxt[1];
      out_word_r.cov_yy     <= cov_nxt[2];
    end
  end

endmodule

FILE: verif/range_bearing_landmark_birth_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_bearing_landmark_birth_tb
// Drives pose and range-bearing words through the landmark birth pipe and
// compares most landmark words against a bit-exact fixed-point predictor of
// the angle wrap, sine/cosine series, position and G*R*G' covariance. Noise
// registers are reprogrammed between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module range_bearing_landmark_birth_tb;
  import rblb_pkg::*;

  localparam int         HALF_PERIOD = 6;
  localparam int         PIPE_DRAIN  = 40;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_WORDS = 325;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam longint     Q30_ONE     = 64'sd1073741824;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Noise matrix as the predictor sees it
  longint noise_rr, noise_rb, noise_bb;

  out_word_t landmark_q[$];
  int        fail_count = 0;
  int        cycle_count = 0;

  range_bearing_landmark_birth DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Cycle count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // No idling on either side inside this window
  function automatic bit calm_window();
    return cycle_count >= 3000 && cycle_count < 6000;
  endfunction

  function automatic bit idle_now();
    return !calm_window() && ($urandom_range(99) < 36);
  endfunction

  // floor(a*b / 2^n), low 64 bits
  function automatic longint mul_floor(longint a, longint b, int n);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = (pa * pb) >>> n;
    return p[63:0];
  endfunction

  function automatic void sin_cos_q30(longint a13, output longint s_o, output longint c_o);
    longint x, y, y2, ts, tc, s, c;
    int quad;
    x = a13 * 131072;
    if (x > THREE_QTR_PI_Q30) begin
      quad = 2; y = x - PI_Q30;
    end else if (x > QTR_PI_Q30) begin
      quad = 1; y = x - HALF_PI_Q30;
    end else if (x >= -QTR_PI_Q30) begin
      quad = 0; y = x;
    end else if (x >= -THREE_QTR_PI_Q30) begin
      quad = 3; y = x + HALF_PI_Q30;
    end else begin
      quad = 2; y = x + PI_Q30;
    end
    y2 = mul_floor(y, y, 30);
    ts = Q30_ONE - y2 / 72;
    ts = Q30_ONE - mul_floor(y2, ts, 30) / 42;
    ts = Q30_ONE - mul_floor(y2, ts, 30) / 20;
    ts = Q30_ONE - mul_floor(y2, ts, 30) / 6;
    s = mul_floor(y, ts, 30);
    tc = Q30_ONE - y2 / 56;
    tc = Q30_ONE - mul_floor(y2, tc, 30) / 30;
    tc = Q30_ONE - mul_floor(y2, tc, 30) / 12;
    c = Q30_ONE - mul_floor(y2, tc, 30) / 2;
    case (quad)
      0: begin s_o = s; c_o = c; end
      1: begin s_o = c; c_o = -s; end
      2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endfunction

  // One covariance entry: Q46 sum, floor to Q32.32, saturate
  function automatic logic [63:0] cov_sum(longint g1, longint g2, longint g3);
    logic signed [127:0] acc, t1, t2, t3, r1, r2, r3;
    t1 = g1; t2 = g2; t3 = g3;
    r1 = noise_rr; r2 = noise_rb; r3 = noise_bb;
    acc = (t1 * r1 + t2 * r2 + t3 * r3) >>> 14;
    if (acc[127:63] == '0 || acc[127:63] == '1) return acc[63:0];
    return acc[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic out_word_t predict_landmark(in_word_t w);
    out_word_t o;
    longint ang, s, c, rng, rc, rs;
    ang = longint'(w.pose_heading) + longint'(w.measured_bearing);
    if (ang >= PI_Q13) ang = ang - TWO_PI_Q13;
    else if (ang < -PI_Q13) ang = ang + TWO_PI_Q13;
    sin_cos_q30(ang, s, c);
    rng = longint'({32'b0, w.measured_range});
    rc = mul_floor(rng, c, 30);
    rs = mul_floor(rng, s, 30);
    o.landmark_x = clamp32(longint'(w.pose_x) + rc);
    o.landmark_y = clamp32(longint'(w.pose_y) + rs);
    o.cov_xx = cov_sum(mul_floor(c, c, 30), -2 * mul_floor(c, rs, 16), mul_floor(rs, rs, 2));
    o.cov_xy = cov_sum(mul_floor(c, s, 30),
                       mul_floor(c, rc, 16) - mul_floor(s, rs, 16), -mul_floor(rs, rc, 2));
    o.cov_yy = cov_sum(mul_floor(s, s, 30), 2 * mul_floor(s, rc, 16), mul_floor(rc, rc, 2));
    return o;
  endfunction

  // Send one word; queue its landmark once accepted
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_exp);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    landmark_q.push_back(typed ? typed_exp : predict_landmark(w));
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    while (landmark_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RANGE_VAR:   noise_rr = longint'(signed'(data));
      REG_CROSS_COV:   noise_rb = longint'(signed'(data));
      REG_BEARING_VAR: noise_bb = longint'(signed'(data));
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    w.pose_x = $urandom();
    w.pose_y = $urandom();
    w.pose_heading = 16'($urandom());
    w.measured_bearing = 16'($urandom());
    case ($urandom_range(3))
      0: w.measured_range = $urandom();
      1: w.measured_range = $urandom_range(32'hFFFF);
      default: w.measured_range = $urandom_range(32'h00FF_FFFF);
    endcase
    // Keep poses modest most of the time so positions rarely clip
    if ($urandom_range(3) != 0) begin
      w.pose_x = signed'(w.pose_x) >>> 8;
      w.pose_y = signed'(w.pose_y) >>> 8;
    end
    return w;
  endfunction

  function automatic in_word_t make_word(logic [31:0] px, logic [31:0] py, logic [15:0] hd,
                                         logic [31:0] rg, logic [15:0] br);
    in_word_t w;
    w.pose_x = px; w.pose_y = py; w.pose_heading = hd;
    w.measured_range = rg; w.measured_bearing = br;
    return w;
  endfunction

  // Check each accepted landmark word against the oldest expectation
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (landmark_q.size() == 0) begin
        $display("%0t: unexpected landmark word %h", $time, out_word);
        fail_count++;
      end else begin
        e = landmark_q.pop_front();
        if (e.landmark_x !== out_word.landmark_x) begin
          $display("%0t: landmark_x exp %h got %h", $time, e.landmark_x, out_word.landmark_x);
          fail_count++;
        end
        if (e.landmark_y !== out_word.landmark_y) begin
          $display("%0t: landmark_y exp %h got %h", $time, e.landmark_y, out_word.landmark_y);
          fail_count++;
        end
        if (e.cov_xx !== out_word.cov_xx) begin
          $display("%0t: cov_xx exp %h got %h", $time, e.cov_xx, out_word.cov_xx);
          fail_count++;
        end
        if (e.cov_xy !== out_word.cov_xy) begin
          $display("%0t: cov_xy exp %h got %h", $time, e.cov_xy, out_word.cov_xy);
          fail_count++;
        end
        if (e.cov_yy !== out_word.cov_yy) begin
          $display("%0t: cov_yy exp %h got %h", $time, e.cov_yy, out_word.cov_yy);
          fail_count++;
        end
      end
    end
    out_stall <= rst_n && idle_now();
  end

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t e;
  } birth_row_t;

  birth_row_t directed[$];

  initial begin
    logic [31:0] noise_sets[5][3];
    out_word_t   none;
    none = '0;
    noise_rr = RANGE_VAR_RST;
    noise_rb = CROSS_COV_RST;
    noise_bb = BEARING_VAR_RST;

    // Directed table: typed rows first, then corners checked by the predictor
    directed.push_back('{make_word(32'd5, 32'd7, 16'd0, 32'd0, 16'd0), 1'b1,
                         '{32'd5, 32'd7, 64'h1_0000_0000, 64'd0, 64'd0}});
    directed.push_back('{make_word(32'h7FFF_FFFF, 32'h1234, 16'd0, 32'hFFFF_FFFF, 16'd0), 1'b1,
                         '{32'h7FFF_FFFF, 32'h1234, 64'h1_0000_0000, 64'd0,
                           64'h7FFF_FFFF_FFFF_FFFF}});
    directed.push_back('{make_word(32'h8000_0000, 32'h8000_0000, 16'd25736, 32'hFFFF_FFFF,
                                   16'd0), 1'b0, none});
    directed.push_back('{make_word(32'h0, 32'h0, 16'h8000, 32'h10000, 16'h8000), 1'b0, none});
    directed.push_back('{make_word(32'h0, 32'h0, 16'h7FFF, 32'h10000, 16'h7FFF), 1'b0, none});
    directed.push_back('{make_word(32'h0, 32'h0, -16'sd25736, 32'h20000, -16'sd1), 1'b0, none});
    directed.push_back('{make_word(32'h0, 32'h0, -16'sd25736, 32'h20000, 16'd0), 1'b0, none});
    directed.push_back('{make_word(32'h100, 32'h200, 16'd6434, 32'h30000, 16'd0), 1'b0, none});
    directed.push_back('{make_word(32'h100, 32'h200, 16'd6435, 32'h30000, 16'd0), 1'b0, none});
    directed.push_back('{make_word(32'h100, 32'h200, -16'sd6434, 32'h30000, 16'd0), 1'b0, none});
    directed.push_back('{make_word(32'h100, 32'h200, -16'sd6435, 32'h30000, 16'd0), 1'b0, none});
    directed.push_back('{make_word(32'h0, 32'h0, 16'd19302, 32'h50000, 16'd0), 1'b0, none});
    directed.push_back('{make_word(32'h0, 32'h0, -16'sd19302, 32'h50000, 16'd0), 1'b0, none});
    directed.push_back('{make_word(32'h0, 32'h0, 16'd12868, 32'hFFFF_FFFF, 16'd0), 1'b0, none});
    directed.push_back('{make_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'd12868, 32'hFFFF_FFFF,
                                   16'd100), 1'b0, none});
    directed.push_back('{make_word(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 32'hAAAA_AAAA,
                                   16'hAAAA), 1'b0, none});

    // Noise settings per later phase: extremes, zero, negative, random
    noise_sets[0] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    noise_sets[1] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    noise_sets[2] = '{32'h0, 32'h0, 32'h0};
    noise_sets[3] = '{32'h0004_0000, 32'hFFFF_8000, 32'h0000_0100};
    noise_sets[4] = '{$urandom(), $urandom(), $urandom()};

    // Hold reset
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_word(directed[i].w, directed[i].typed, directed[i].e);

    for (int ph = 0; ph <= 5; ph++) begin
      if (ph > 0) begin
        wait_empty();
        repeat (PIPE_DRAIN) @(posedge clk);
        write_reg(REG_RANGE_VAR, noise_sets[ph - 1][0]);
        write_reg(REG_CROSS_COV, noise_sets[ph - 1][1]);
        write_reg(REG_BEARING_VAR, noise_sets[ph - 1][2]);
        // Out-of-range index must be dropped
        write_reg(REG_UNUSED, $urandom());
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Hold the sender until the pipe runs dry once per phase
        if (n == PHASE_WORDS / 2) wait_empty();
        send_word(random_word(), 1'b0, none);
      end
    end

    wait_empty();
    repeat (PIPE_DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rblb_pkg.sv
rtl/range_bearing_landmark_birth.sv
verif/range_bearing_landmark_birth_tb.sv
